[hdl/rdc_pkg.sv]
`default_nettype none

package rdc_pkg;

  localparam int VALUE_W     = 64;
  localparam int SYM_W       = 8;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_DIGITS  = 64;
  localparam int DIGIT_AW    = $clog2(MAX_DIGITS);
  localparam int COUNT_W     = DIGIT_AW + 1;
  localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
  localparam int STEP_BITS   = 4;
  localparam int STEP_CNT_W  = $clog2(VALUE_W / STEP_BITS);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH    = 2'd2;

  localparam logic [RADIX_W-1:0] ALEN_RESET    = 5'd10;
  localparam logic [VALUE_W-1:0] SYM_LO_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [VALUE_W-1:0] SYM_HI_RESET  = 64'h0000_0000_0000_3938;

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SINGLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;   // take a new dividend
    logic start;  // begin one division pass on the held dividend
  } div_ctrl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               more;  // quotient of the finished pass is nonzero
  } div_stat_t;

  function automatic logic [SYM_W-1:0] symbol_at(input logic [VALUE_W-1:0] lo,
                                                 input logic [VALUE_W-1:0] hi,
                                                 input logic [SYM_IDX_W-1:0] k);
    logic [VALUE_W-1:0] word;
    word = k[SYM_IDX_W-1] ? hi : lo;
    return word[{k[2:0], 3'b000} +: SYM_W];
  endfunction

endpackage

`default_nettype wire

[hdl/rdc_divider.sv]
`default_nettype none

module rdc_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rdc_pkg::div_ctrl_t          ctrl,
  input  wire logic [rdc_pkg::VALUE_W-1:0] dividend,
  input  wire logic [rdc_pkg::RADIX_W-1:0] radix,
  output rdc_pkg::div_stat_t               stat
);
  import rdc_pkg::*;

  logic [VALUE_W-1:0]    shift_r;
  logic [DIGIT_W-1:0]    rem_r;
  logic [STEP_CNT_W-1:0] step_r;
  logic                  busy_r;
  logic                  nz_r;

  logic [DIGIT_W-1:0]    rem_nxt;
  logic [STEP_BITS-1:0]  qn;
  logic                  last_step;

  // One nibble of the dividend per cycle, restoring division, MSB first.
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic [DIGIT_W-1:0] r;
    r = rem_r;
    qn = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, shift_r[VALUE_W-1-i]};
      if (t >= radix) begin
        qn[STEP_BITS-1-i] = 1'b1;
        t = t - radix;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_nxt = r;
  end

  assign last_step  = busy_r && (step_r == {STEP_CNT_W{1'b1}});
  assign stat.busy  = busy_r;
  assign stat.done  = last_step;
  assign stat.digit = rem_nxt;
  assign stat.more  = nz_r || (qn != '0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shift_r <= dividend;
    end else if (busy_r) begin
      shift_r <= {shift_r[VALUE_W-STEP_BITS-1:0], qn};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      rem_r  <= '0;
      nz_r   <= 1'b0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      rem_r  <= '0;
      nz_r   <= 1'b0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      rem_r  <= rem_nxt;
      nz_r   <= nz_r || (qn != '0);
      if (last_step) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/radix_digit_converter_core.sv]
// Flow: each item runs an alphabet check over all 16 symbol slots, then one division pass
//   per digit, then reads and emits the stored digits most significant first (up to 64 digits).
// Zero values and bad alphabets give a single result once the check is done.
// Throughput: one item at a time; the nibble-serial divider sets the per-digit cost.
// Reset: synchronous, active-low rst_n clears control and reloads the alphabet registers
//   (radix 10, "0123456789"); the digit store is not cleared.
`default_nettype none

module radix_digit_converter_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rdc_pkg::VALUE_W-1:0]   cfg_wdata,
  // input stream
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [rdc_pkg::VALUE_W-1:0]   in_tdata,   // [63:0] value
  // result stream
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [rdc_pkg::SYM_W-1:0]     out_tdata,  // [7:0] digit_char
  output      logic                          out_tlast,  // last_digit
  output      logic                          out_tuser   // [0] bad_alphabet
);
  import rdc_pkg::*;

  // Configuration registers
  logic [RADIX_W-1:0] alen_r;
  logic [VALUE_W-1:0] sym_lo_r;
  logic [VALUE_W-1:0] sym_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r   <= ALEN_RESET;
      sym_lo_r <= SYM_LO_RESET;
      sym_hi_r <= SYM_HI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHABET_LENGTH: alen_r   <= cfg_wdata[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:     sym_lo_r <= cfg_wdata;
        CFG_SYMBOLS_HIGH:    sym_hi_r <= cfg_wdata;
        default:             ;  // drop writes to unused indexes
      endcase
    end
  end

  // Control state
  state_t               state_r, state_nxt;
  logic [SYM_IDX_W-1:0] chk_r, chk_nxt;
  logic                 bad_r, bad_nxt;
  logic                 zero_r, zero_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [DIGIT_AW-1:0]  rd_idx_r, rd_idx_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_user_r, out_user_nxt;
  logic               out_load;
  logic               out_free;

  // Digit store
  logic [DIGIT_W-1:0] store_r [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_r;
  logic               store_we;

  // Divider
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  logic       in_xfer;
  logic       len_bad;
  logic       chk_hit;
  logic [SYM_W-1:0] sym_a;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign len_bad  = (alen_r < RADIX_W'(2)) || (alen_r > RADIX_W'(MAX_SYMBOLS));

  rdc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (in_tdata),
    .radix    (alen_r),
    .stat     (div_stat)
  );

  // Symbol chk_r against sign characters and every later symbol in the alphabet.
  always_comb begin
    sym_a   = symbol_at(sym_lo_r, sym_hi_r, chk_r);
    chk_hit = 1'b0;
    if ({1'b0, chk_r} < alen_r) begin
      if ((sym_a == CHAR_PLUS) || (sym_a == CHAR_MINUS)) begin
        chk_hit = 1'b1;
      end
      for (int b = 0; b < MAX_SYMBOLS; b++) begin
        if ((SYM_IDX_W'(b) > chk_r) && (RADIX_W'(b) < alen_r) &&
            (symbol_at(sym_lo_r, sym_hi_r, SYM_IDX_W'(b)) == sym_a)) begin
          chk_hit = 1'b1;
        end
      end
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt      = state_r;
    chk_nxt        = chk_r;
    bad_nxt        = bad_r;
    zero_nxt       = zero_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    in_tready      = 1'b0;
    div_ctrl.load  = 1'b0;
    div_ctrl.start = 1'b0;
    store_we       = 1'b0;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_user_nxt   = out_user_r;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          // hand the value to the divider now; it holds until the check is done
          div_ctrl.load = 1'b1;
          zero_nxt      = (in_tdata == '0);
          bad_nxt       = len_bad;
          chk_nxt       = '0;
          state_nxt     = ST_CHECK;
        end
      end

      ST_CHECK: begin
        bad_nxt = bad_r || chk_hit;
        chk_nxt = chk_r + 1'b1;
        if (chk_r == SYM_IDX_W'(MAX_SYMBOLS - 1)) begin
          if (zero_r || bad_nxt) begin
            state_nxt = ST_SINGLE;
          end else begin
            div_ctrl.start = 1'b1;
            count_nxt      = '0;
            state_nxt      = ST_DIVIDE;
          end
        end
      end

      ST_DIVIDE: begin
        if (div_stat.done) begin
          store_we  = 1'b1;
          count_nxt = count_r + 1'b1;
          // keep dividing while the quotient is nonzero and the store has room
          if (div_stat.more && (count_r[DIGIT_AW-1:0] != DIGIT_AW'(MAX_DIGITS - 1))) begin
            div_ctrl.start = 1'b1;
          end else begin
            rd_idx_nxt = count_r[DIGIT_AW-1:0];
            state_nxt  = ST_READ;
          end
        end
      end

      ST_SINGLE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = zero_r ? CHAR_ZERO : '0;
          out_last_nxt = 1'b1;
          out_user_nxt = !zero_r && bad_r;
          state_nxt    = ST_IDLE;
        end
      end

      ST_READ: begin
        // store read is registered; data shows up in ST_EMIT
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = symbol_at(sym_lo_r, sym_hi_r, rd_data_r);
          out_last_nxt = (rd_idx_r == '0);
          out_user_nxt = 1'b0;
          if (rd_idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_r       <= '0;
      bad_r       <= 1'b0;
      zero_r      <= 1'b0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_r       <= chk_nxt;
      bad_r       <= bad_nxt;
      zero_r      <= zero_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the output register holds until the next load.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  // Digit store: one write port during division, one registered read port for emit.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r[DIGIT_AW-1:0]] <= div_stat.digit;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_r[rd_idx_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // Divider runs only while a conversion is in progress.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIVIDE))
    else $error("division pass finished outside divide state");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ({1'b0, rd_idx_r} < count_r))
    else $error("digit store read beyond written digits");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten before transfer");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CHECK))
    else $error("accepted item did not enter alphabet check");

endmodule

`default_nettype wire

[tb/tb_radix_digit_converter_core.sv]
`timescale 1ns / 1ps

module tb_radix_digit_converter_core;
  import rdc_pkg::*;

  // Default decimal alphabet as one 128-bit word, symbol 0 in the low byte.
  localparam logic [127:0] DEC_ALPHA = {SYM_HI_RESET, SYM_LO_RESET};

  typedef struct packed {
    logic [SYM_W-1:0] digit_char;
    logic             last_digit;
    logic             bad_alphabet;
  } digit_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0]   cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [VALUE_W-1:0]   in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SYM_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;

  // Shadow copy of the configuration registers, updated on every write.
  logic [RADIX_W-1:0]   radix_len = ALEN_RESET;
  logic [VALUE_W-1:0]   sym_lo = SYM_LO_RESET;
  logic [VALUE_W-1:0]   sym_hi = SYM_HI_RESET;

  // Digits still owed by the block, oldest first.
  digit_t pending_digits[$];

  bit src_idle_on = 1'b1;
  bit sink_stall_on = 1'b1;
  int stall_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int digits_seen = 0;

  radix_digit_converter_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [63:0] value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] digit_char
    .out_tlast  (out_tlast),   // last_digit
    .out_tuser  (out_tuser)    // [0] bad_alphabet
  );

  always #5 clk = ~clk;

  // Work out the digit string for one value from the shadow registers and queue it.
  function automatic void predict_digits(input logic [VALUE_W-1:0] v);
    logic [127:0]       alpha;
    logic [DIGIT_W-1:0] rems[$];
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] r;
    logic [SYM_W-1:0]   c;
    int unsigned        len;
    bit                 ok;
    alpha = {sym_hi, sym_lo};
    len = radix_len;
    // a zero value always prints a single ASCII zero, alphabet unchecked
    if (v == '0) begin
      pending_digits.push_back({CHAR_ZERO, 1'b1, 1'b0});
      return;
    end
    ok = (len >= 2) && (len <= MAX_SYMBOLS);
    for (int a = 0; ok && a < len; a++) begin
      c = alpha[8*a +: 8];
      if (c == CHAR_PLUS || c == CHAR_MINUS) ok = 1'b0;
      for (int b = a + 1; b < len; b++)
        if (alpha[8*b +: 8] == c) ok = 1'b0;
    end
    if (!ok) begin
      pending_digits.push_back({8'h00, 1'b1, 1'b1});
      return;
    end
    rest = v;
    while (rest != '0) begin
      r = rest % len;
      rems.push_front(r[DIGIT_W-1:0]);
      rest = rest / len;
    end
    foreach (rems[i])
      pending_digits.push_back({alpha[8*rems[i] +: 8], i == rems.size() - 1, 1'b0});
  endfunction

  // Sixteen distinct random bytes, none of them a sign character.
  function automatic logic [127:0] pick_alphabet();
    bit [255:0]   taken;
    logic [127:0] alpha;
    int unsigned  c;
    taken = '0;
    taken[CHAR_PLUS] = 1'b1;
    taken[CHAR_MINUS] = 1'b1;
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      c = $urandom_range(0, 255);
      while (taken[c]) c = $urandom_range(0, 255);
      taken[c] = 1'b1;
      alpha[8*k +: 8] = c[7:0];
    end
    return alpha;
  endfunction

  // Mix of zero, small, single-bit, all-ones, radix powers and full random values.
  function automatic logic [VALUE_W-1:0] gen_value(input int unsigned radix);
    logic [VALUE_W-1:0] p;
    int unsigned        e;
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        p = $urandom_range(1, 255);
        return p;
      end
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~64'd0 >> $urandom_range(0, 63);
      4: begin
        // a power of the radix, or one below it, to hit digit-count boundaries
        p = 64'd1;
        e = $urandom_range(1, 64);
        if (radix >= 2 && radix <= MAX_SYMBOLS)
          repeat (e) if (p <= ~64'd0 / radix) p = p * radix;
        return p - $urandom_range(0, 1);
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Register write: raise the enable at one falling edge, drop it at the next.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ALPHABET_LENGTH: radix_len = data[RADIX_W-1:0];
      CFG_SYMBOLS_LOW:     sym_lo = data;
      CFG_SYMBOLS_HIGH:    sym_hi = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_alphabet(input logic [RADIX_W-1:0] len, input logic [127:0] alpha);
    logic [VALUE_W-1:0] w;
    // junk above the length field must be ignored
    w = {$urandom, $urandom};
    w[RADIX_W-1:0] = len;
    set_reg(CFG_ALPHABET_LENGTH, w);
    set_reg(CFG_SYMBOLS_LOW, alpha[63:0]);
    set_reg(CFG_SYMBOLS_HIGH, alpha[127:64]);
  endtask

  task automatic wait_drained();
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // Offer one value, optionally after a short idle burst, and hold until it transfers.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (src_idle_on && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tdata <= {$urandom, $urandom};
      end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_digits(v);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic try_alphabet(input logic [RADIX_W-1:0] len, input logic [127:0] alpha,
                              input logic [VALUE_W-1:0] v);
    wait_drained();
    set_alphabet(len, alpha);
    send_value(v);
    release_input();
  endtask

  // Decimal from reset: zero, single digit, carry into two digits, longest value.
  task automatic test_reset_defaults();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(~64'd0);
    send_value(64'd1234567890);
    release_input();
  endtask

  // Base 2 gives the longest runs; junk past the second symbol must not matter.
  task automatic test_binary_long_runs();
    wait_drained();
    set_alphabet(5'd2, {~64'd0, 64'h302D_2B30_2D2B_3130});
    send_value(~64'd0);
    send_value(64'd1);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd0);
    send_value(64'h5555_5555_5555_5555);
    release_input();
  endtask

  // Radix 16 with raw byte symbols, including 0x00 and 0xFF.
  task automatic test_hex_raw_bytes();
    wait_drained();
    set_alphabet(5'd16, {64'hFEDC_BA98_7654_3210, 64'h7F80_55AA_0102_FF00});
    send_value(~64'd0);
    send_value(64'h0123_4567_89AB_CDEF);
    send_value(64'd15);
    send_value(64'd16);
    release_input();
  endtask

  // Each way an alphabet can be rejected, plus a zero value that bypasses the check.
  task automatic test_bad_alphabets();
    logic [127:0] alpha;
    try_alphabet(5'd0, DEC_ALPHA, 64'd5);
    try_alphabet(5'd1, DEC_ALPHA, ~64'd0);
    try_alphabet(5'd17, DEC_ALPHA, 64'd1);
    try_alphabet(5'd31, DEC_ALPHA, 64'd7);
    try_alphabet(5'd2, {64'd0, ~64'd0}, 64'd3);
    try_alphabet(5'd10, {64'd0, SYM_LO_RESET}, 64'd100);
    send_value(64'd0);
    release_input();
    alpha = DEC_ALPHA;
    alpha[8*2 +: 8] = CHAR_PLUS;
    try_alphabet(5'd4, alpha, 64'd9);
    alpha = DEC_ALPHA;
    alpha[7:0] = CHAR_MINUS;
    try_alphabet(5'd3, alpha, 64'd1);
  endtask

  // Random alphabets, mostly valid, some broken in each possible way.
  task automatic test_random_phases();
    logic [127:0] alpha;
    int unsigned  len;
    int unsigned  a;
    int unsigned  b;
    for (int p = 0; p < 12; p++) begin
      wait_drained();
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_stall_on = ($urandom_range(0, 3) != 0);
      alpha = pick_alphabet();
      len = $urandom_range(2, MAX_SYMBOLS);
      case ($urandom_range(0, 9))
        0: len = $urandom_range(0, 1);
        1: len = $urandom_range(MAX_SYMBOLS + 1, 31);
        2: begin
          a = $urandom_range(0, len - 2);
          b = $urandom_range(a + 1, len - 1);
          alpha[8*b +: 8] = alpha[8*a +: 8];
        end
        3: begin
          a = $urandom_range(0, len - 1);
          alpha[8*a +: 8] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
        end
        4: begin
          // poison only symbols past the length; the alphabet stays valid
          if (len < MAX_SYMBOLS) begin
            a = $urandom_range(len, MAX_SYMBOLS - 1);
            alpha[8*a +: 8] = $urandom_range(0, 1) ? CHAR_PLUS : alpha[7:0];
          end
        end
        default: ;
      endcase
      set_alphabet(len[RADIX_W-1:0], alpha);
      repeat (20) send_value(gen_value(len));
      release_input();
    end
  endtask

  // Back-to-back stream with no gaps or stalls on a valid alphabet.
  task automatic test_steady_stream();
    int unsigned len;
    wait_drained();
    src_idle_on = 1'b0;
    sink_stall_on = 1'b0;
    len = $urandom_range(2, MAX_SYMBOLS);
    set_alphabet(len[RADIX_W-1:0], pick_alphabet());
    repeat (40) send_value(gen_value(len));
    release_input();
  endtask

  // Sink side: hold tready low for bursts of random length.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stall_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every result transfer against the oldest pending digit.
  always @(posedge clk) begin : check_digit
    digit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      digits_seen++;
      if (pending_digits.size() == 0) begin
        $error("digit_char %02h arrived with no digit pending", out_tdata);
        error_count++;
      end else begin
        want = pending_digits.pop_front();
        if (out_tdata !== want.digit_char) begin
          $error("digit_char: expected %02h, got %02h", want.digit_char, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last_digit) begin
          $error("last_digit: expected %0b, got %0b", want.last_digit, out_tlast);
          error_count++;
        end
        if (out_tuser !== want.bad_alphabet) begin
          $error("bad_alphabet: expected %0b, got %0b", want.bad_alphabet, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_binary_long_runs();
    test_hex_raw_bytes();
    test_bad_alphabets();
    test_random_phases();
    test_steady_stream();

    // drain, then watch a little longer for stray transfers
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Converted %0d values into %0d digit transfers: radix 2 to 16, raw byte symbols,",
             items_sent, digits_seen);
    $display("rejected alphabets, random gaps and stalls, then a gap-free stream.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(25_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
